// ----- hdl/lru_page_replacement_unit_assert.svh -----
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_assert
// Assertion macros shared by the LRU page replacement unit.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared sizes and types of the LRU page replacement unit: the scan
// wave that travels through the frame cells and the update broadcast.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

    localparam int FRAMES     = 16;
    localparam int PAGE_BITS  = 16;

    localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W     = IDX_W;
    localparam int ORANK_W    = RANK_W + 1;
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int PAGE_IO_W  = 16;
    localparam int FAULT_W    = 32;
    localparam int FRAME_IO_W = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USED_W = 1 + FRAME_IO_W + 1 + PAGE_IO_W + FAULT_W;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [ORANK_W-1:0]   t_orank;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam t_rank RANK_MAX  = t_rank'(FRAMES - 1);
    localparam t_orank RANK_NEW = t_orank'(FRAMES);

    // Partial search result carried from cell to cell.
    typedef struct packed {
        logic  vld;
        t_page page;
        logic  hit;
        t_idx  hit_idx;
        t_rank hit_rank;
        logic  empty;
        t_idx  empty_idx;
        logic  best_set;
        t_rank best_rank;
        t_idx  best_idx;
        t_page best_page;
    } t_carry;

    // Decision broadcast to every cell in the write cycle.
    typedef struct packed {
        logic   en;
        logic   fill;
        t_idx   frame;
        t_orank old_rank;
        t_page  page;
    } t_upd;

endpackage

`default_nettype wire

// ----- hdl/lpr_cell.sv -----
// ----------------------------------------------------------------------------
// lpr_cell
// One frame of the chain: holds page, valid bit and age rank, folds
// itself into the passing search wave and applies the update broadcast.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  lpr_pkg::t_idx     i_cell_idx,
    input  lpr_pkg::t_cnt     i_frames,
    input  lpr_pkg::t_carry   i_carry,
    input  lpr_pkg::t_upd     i_upd,
    output lpr_pkg::t_carry   o_carry
);
    import lpr_pkg::*;

    t_page  r_page;
    logic   r_valid;
    t_rank  r_rank;
    t_carry r_carry;
    t_carry n_carry;
    logic   w_active;

    assign w_active = (CNT_W'(i_cell_idx) < i_frames);

    always_comb begin
        n_carry = i_carry;
        if (w_active && i_carry.vld) begin
            if (r_valid && (r_page == i_carry.page) && !i_carry.hit) begin
                n_carry.hit      = 1'b1;
                n_carry.hit_idx  = i_cell_idx;
                n_carry.hit_rank = r_rank;
            end
            if (!r_valid && !i_carry.empty) begin
                n_carry.empty     = 1'b1;
                n_carry.empty_idx = i_cell_idx;
            end
            // The first active frame seeds the oldest-frame search; later
            // frames replace it only with a strictly older rank.
            if (!i_carry.best_set || (r_rank > i_carry.best_rank)) begin
                n_carry.best_set  = 1'b1;
                n_carry.best_rank = r_rank;
                n_carry.best_idx  = i_cell_idx;
                n_carry.best_page = r_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.vld <= 1'b0;
        end else begin
            r_carry <= n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en && w_active) begin
            if (i_upd.frame == i_cell_idx) begin
                r_rank <= '0;
                if (i_upd.fill) begin
                    r_valid <= 1'b1;
                end
            end else if (r_valid && (ORANK_W'(r_rank) < i_upd.old_rank)
                         && (r_rank != RANK_MAX)) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && w_active && (i_upd.frame == i_cell_idx) && i_upd.fill) begin
            r_page <= i_upd.page;
        end
    end

    assign o_carry = r_carry;

endmodule

`default_nettype wire

// ----- hdl/lru_page_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative LRU page replacement over a chain of frame cells.
//
//   channel   direction  handshake            payload
//   s_axis    in         i_s_tvalid/o_s_tready page reference
//   m_axis    out        o_m_tvalid/i_m_tready hit, frame, eviction, faults
//   cfg       in         i_cfg_we             frames in use
//
// A request is registered at the head of the search wave and passes the cell
// chain one cell register at a time; the decision is registered before write-back,
// which registers the result; the next request is taken once the unit is idle again.
// The write-back cycle waits while the previous result is still held.
// Reset is synchronous and active low; it empties all frames, clears
// ranks and the fault count, and sets frames in use to 16.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_page_replacement_unit_assert.svh"

module lru_page_replacement_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [lpr_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] page_number
    input  wire  [lpr_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // [0] was_hit, [4:1] frame_used, [5] evicted_valid,
    // [21:6] evicted_page, [53:22] fault_total, [55:54] zero
    output logic [lpr_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import lpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_cfg;
    t_cnt                  w_frames;
    t_carry                r_launch;
    t_carry                n_launch;
    t_carry                w_carry [FRAMES+1];
    t_carry                r_dec;
    t_upd                  w_upd;
    logic                  w_accept;
    logic                  w_go;
    logic                  w_evict;
    t_idx                  w_frame;
    logic [FAULT_W-1:0]    r_fault;
    logic [FAULT_W-1:0]    n_fault;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    always_comb begin
        if (r_cfg == '0) begin
            w_frames = t_cnt'(1);
        end else if (int'(r_cfg) > FRAMES) begin
            w_frames = t_cnt'(FRAMES);
        end else begin
            w_frames = t_cnt'(r_cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_go       = (r_state == S_WRITE) && (!r_out_vld || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_carry[FRAMES].vld) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (w_go) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Head of the search wave; only page and vld matter at entry.
    always_comb begin
        n_launch      = '0;
        n_launch.vld  = w_accept;
        n_launch.page = i_s_tdata[PAGE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch.vld <= 1'b0;
        end else begin
            r_launch <= n_launch;
        end
    end

    assign w_carry[0] = r_launch;

    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        lpr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (t_idx'(i)),
            .i_frames   (w_frames),
            .i_carry    (w_carry[i]),
            .i_upd      (w_upd),
            .o_carry    (w_carry[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && w_carry[FRAMES].vld) begin
            r_dec <= w_carry[FRAMES];
        end
    end

    assign w_evict = !r_dec.hit && !r_dec.empty;

    always_comb begin
        if (r_dec.hit) begin
            w_frame = r_dec.hit_idx;
        end else if (r_dec.empty) begin
            w_frame = r_dec.empty_idx;
        end else begin
            w_frame = r_dec.best_idx;
        end
    end

    always_comb begin
        w_upd.en       = w_go;
        w_upd.fill     = !r_dec.hit;
        w_upd.frame    = w_frame;
        w_upd.old_rank = r_dec.hit ? ORANK_W'(r_dec.hit_rank) : RANK_NEW;
        w_upd.page     = r_dec.page;
    end

    assign n_fault = (!r_dec.hit && (r_fault != '1)) ? r_fault + 1'b1 : r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (w_go) begin
            r_fault <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_go) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_data <= {{OUT_PAD_W{1'b0}},
                           n_fault,
                           w_evict ? PAGE_IO_W'(r_dec.best_page) : PAGE_IO_W'(0),
                           w_evict,
                           FRAME_IO_W'(w_frame),
                           r_dec.hit};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    `LPR_ASSERT_NOW(a_tail_in_scan, i_clk, i_rst_n, w_carry[FRAMES].vld,
        r_state == S_SCAN, "search wave left the chain outside the scan state")
    `LPR_ASSERT_NEXT(a_accept_launch, i_clk, i_rst_n, w_accept,
        (r_state == S_SCAN) && r_launch.vld, "accepted request did not launch a search")
    `LPR_ASSERT_NEXT(a_hit_no_fault, i_clk, i_rst_n, w_go && r_dec.hit,
        $stable(r_fault), "fault count changed on a hit")
    `LPR_ASSERT_NEXT(a_miss_counts, i_clk, i_rst_n, w_go && !r_dec.hit && (r_fault != '1),
        r_fault == $past(r_fault) + 1'b1, "fault count did not advance on a miss")

endmodule

`default_nettype wire
